[src/rmq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;
  localparam int FRAC_BITS = 30;
  localparam int DATA_W    = 32;
  localparam int TERM_W    = DATA_W + 2;
  localparam int PAIR_W    = DATA_W + 1;
  localparam int RAD_W     = DATA_W + 1;
  localparam int SQ_BITS   = 32;
  localparam int SQIN_W    = 64;
  localparam int BIG_W     = SQ_BITS - 1;
  localparam int DIV_BITS  = FRAC_BITS;
  localparam int PROD_W    = PAIR_W + DIV_BITS;

  typedef enum logic [1:0] {
    IDX_W = 2'd0,
    IDX_X = 2'd1,
    IDX_Y = 2'd2,
    IDX_Z = 2'd3
  } idx_t;

  typedef struct packed {
    idx_t                   idx;
    logic [2:0][PAIR_W-1:0] pr;
  } side_t;
endpackage
`default_nettype wire

[src/rmq_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface rmq_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
  modport source (output valid, e11, e12, e13, e21, e22, e23, e31, e32, e33, input ready);
  modport sink (input valid, e11, e12, e13, e21, e22, e23, e31, e32, e33, output ready);
endinterface

interface rmq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] qw, qx, qy, qz;
  logic [1:0]         largest_index;
  modport source (output valid, qw, qx, qy, qz, largest_index, input ready);
  modport sink (input valid, qw, qx, qy, qz, largest_index, output ready);
endinterface
`default_nettype wire

[src/rmq_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt
  import rmq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             vld_i,
  input  wire logic [RAD_W-1:0] rad_i,
  input  wire side_t            side_i,
  output logic                  vld_o,
  output logic [SQ_BITS-1:0]    root_o,
  output side_t                 side_o
);
  logic               vld_r  [1:SQ_BITS];
  logic [SQIN_W-1:0]  rem_r  [1:SQ_BITS];
  logic [SQ_BITS-1:0] root_r [1:SQ_BITS];
  side_t              side_r [1:SQ_BITS];

  for (genvar k = 0; k < SQ_BITS; k++) begin : g_stg
    localparam int B = SQ_BITS - 1 - k;
    logic               vld_c;
    logic [SQIN_W-1:0]  rem_c;
    logic [SQ_BITS-1:0] root_c;
    side_t              side_c;
    logic [SQIN_W-1:0]  trial;
    logic               ge;

    if (k == 0) begin : g_first
      assign vld_c  = vld_i;
      assign rem_c  = SQIN_W'(rad_i) << FRAC_BITS;
      assign root_c = '0;
      assign side_c = side_i;
    end else begin : g_next
      assign vld_c  = vld_r[k];
      assign rem_c  = rem_r[k];
      assign root_c = root_r[k];
      assign side_c = side_r[k];
    end

    assign trial = (SQIN_W'(root_c) << (B + 1)) | (SQIN_W'(1) << (2 * B));
    assign ge    = rem_c >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? rem_c - trial : rem_c;
        root_r[k+1] <= ge ? (root_c | (SQ_BITS'(1) << B)) : root_c;
        side_r[k+1] <= side_c;
      end
    end
  end

  assign vld_o  = vld_r[SQ_BITS];
  assign root_o = root_r[SQ_BITS];
  assign side_o = side_r[SQ_BITS];
endmodule
`default_nettype wire

[src/rmq_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module rmq_div
  import rmq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             vld_i,
  input  wire logic [BIG_W-1:0] big_i,
  input  wire side_t            side_i,
  output logic                  vld_o,
  output logic [DIV_BITS-1:0]   quot_o,
  output logic [BIG_W-1:0]      big_o,
  output side_t                 side_o
);
  logic                vld_r  [1:DIV_BITS];
  logic [BIG_W-1:0]    rem_r  [1:DIV_BITS];
  logic [BIG_W-1:0]    d_r    [1:DIV_BITS];
  logic [DIV_BITS-1:0] quot_r [1:DIV_BITS];
  side_t               side_r [1:DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stg
    localparam int B = DIV_BITS - 1 - k;
    logic                vld_c;
    logic [BIG_W-1:0]    rem_c;
    logic [BIG_W-1:0]    d_c;
    logic [DIV_BITS-1:0] quot_c;
    side_t               side_c;
    logic [BIG_W:0]      sh;
    logic [BIG_W:0]      diff;
    logic                ge;

    if (k == 0) begin : g_first
      assign vld_c  = vld_i;
      assign rem_c  = BIG_W'(1) << (FRAC_BITS - 2);
      assign d_c    = big_i;
      assign quot_c = '0;
      assign side_c = side_i;
    end else begin : g_next
      assign vld_c  = vld_r[k];
      assign rem_c  = rem_r[k];
      assign d_c    = d_r[k];
      assign quot_c = quot_r[k];
      assign side_c = side_r[k];
    end

    assign sh   = {rem_c, 1'b0};
    assign diff = sh - {1'b0, d_c};
    assign ge   = sh >= {1'b0, d_c};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? diff[BIG_W-1:0] : sh[BIG_W-1:0];
        d_r[k+1]    <= d_c;
        quot_r[k+1] <= ge ? (quot_c | (DIV_BITS'(1) << B)) : quot_c;
        side_r[k+1] <= side_c;
      end
    end
  end

  assign vld_o  = vld_r[DIV_BITS];
  assign quot_o = quot_r[DIV_BITS];
  assign big_o  = d_r[DIV_BITS];
  assign side_o = side_r[DIV_BITS];
endmodule
`default_nettype wire

[src/rotation_matrix_to_quaternion.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Payload                                  | Handshake
// in_ch   | in  | e11..e33, signed Q2.30, 32 bits each     | valid/ready
// out_ch  | out | qw qx qy qz signed Q2.30, largest_index  | valid/ready
//
// One beat per cycle in, one per cycle out while out_ch is not stalled; stages in order:
// terms, selection, 32 square root stages, 30 divider stages, multiply, output.
// The square root and divider retire one result bit per stage.
// Reset (rst_n low, synchronous) clears all valid bits.
// A stall at out_ch freezes the whole pipeline; in_ch.ready follows it.
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  rmq_in_if.sink    in_ch,
  rmq_out_if.source out_ch
);
  localparam logic signed [TERM_W-1:0] ONE = TERM_W'(1) <<< FRAC_BITS;

  logic en;
  logic out_vld_r;
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // terms and off-diagonal pairs
  logic signed [TERM_W-1:0] a11, a22, a33;
  logic signed [PAIR_W-1:0] e12x, e13x, e21x, e23x, e31x, e32x;
  assign a11  = TERM_W'(in_ch.e11);
  assign a22  = TERM_W'(in_ch.e22);
  assign a33  = TERM_W'(in_ch.e33);
  assign e12x = PAIR_W'(in_ch.e12);
  assign e13x = PAIR_W'(in_ch.e13);
  assign e21x = PAIR_W'(in_ch.e21);
  assign e23x = PAIR_W'(in_ch.e23);
  assign e31x = PAIR_W'(in_ch.e31);
  assign e32x = PAIR_W'(in_ch.e32);

  logic                     v1_r;
  logic signed [TERM_W-1:0] t_r [4];
  logic signed [PAIR_W-1:0] pa_r, pb_r, pc_r, pp_r, ps_r, pq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0] <= a11 + a22 + a33;
      t_r[1] <= a11 - a22 - a33;
      t_r[2] <= a22 - a11 - a33;
      t_r[3] <= a33 - a11 - a22;
      pa_r   <= e32x - e23x;
      pb_r   <= e13x - e31x;
      pc_r   <= e21x - e12x;
      pp_r   <= e21x + e12x;
      ps_r   <= e13x + e31x;
      pq_r   <= e32x + e23x;
    end
  end

  // pick largest term, earliest wins a tie
  idx_t                     idx_sel;
  logic signed [TERM_W-1:0] t_best;
  side_t                    side2_nxt;

  always_comb begin
    idx_sel = IDX_W;
    t_best  = t_r[0];
    if (t_r[1] > t_best) begin
      idx_sel = IDX_X;
      t_best  = t_r[1];
    end
    if (t_r[2] > t_best) begin
      idx_sel = IDX_Y;
      t_best  = t_r[2];
    end
    if (t_r[3] > t_best) begin
      idx_sel = IDX_Z;
      t_best  = t_r[3];
    end
    side2_nxt.idx = idx_sel;
    case (idx_sel)
      IDX_W:   side2_nxt.pr = {pc_r, pb_r, pa_r};
      IDX_X:   side2_nxt.pr = {ps_r, pp_r, pa_r};
      IDX_Y:   side2_nxt.pr = {pq_r, pp_r, pb_r};
      IDX_Z:   side2_nxt.pr = {pq_r, ps_r, pc_r};
      default: side2_nxt.pr = {pc_r, pb_r, pa_r};
    endcase
  end

  logic              v2_r;
  logic [RAD_W-1:0]  rad_r;
  side_t             side2_r;
  logic [TERM_W-1:0] rad_full;
  assign rad_full = t_best + ONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r   <= rad_full[RAD_W-1:0];
      side2_r <= side2_nxt;
    end
  end

  logic               sq_vld;
  logic [SQ_BITS-1:0] sq_root;
  side_t              sq_side;

  rmq_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v2_r),
    .rad_i  (rad_r),
    .side_i (side2_r),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  logic                dv_vld;
  logic [DIV_BITS-1:0] dv_quot;
  logic [BIG_W-1:0]    dv_big;
  side_t               dv_side;

  rmq_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (sq_vld),
    .big_i  (sq_root[SQ_BITS-1:1]),
    .side_i (sq_side),
    .vld_o  (dv_vld),
    .quot_o (dv_quot),
    .big_o  (dv_big),
    .side_o (dv_side)
  );

  // scale the three pairs
  logic              vm_r;
  idx_t              idxm_r;
  logic [BIG_W-1:0]  bigm_r;
  logic              neg_r  [3];
  logic [PROD_W-1:0] prod_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= dv_vld;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_mul
    logic              neg;
    logic [PAIR_W-1:0] mag;
    assign neg = dv_side.pr[i][PAIR_W-1];
    assign mag = neg ? PAIR_W'(-dv_side.pr[i]) : dv_side.pr[i];

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i]  <= neg;
        prod_r[i] <= PROD_W'(mag) * PROD_W'(dv_quot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idxm_r <= dv_side.idx;
      bigm_r <= dv_big;
    end
  end

  // shift, round toward zero, saturate
  logic [DATA_W-1:0] sat [3];
  for (genvar i = 0; i < 3; i++) begin : g_sat
    logic [PAIR_W-1:0] lo;
    logic [PAIR_W-1:0] lim;
    logic [PAIR_W-1:0] m;
    assign lo  = prod_r[i][PROD_W-1:FRAC_BITS];
    assign lim = neg_r[i] ? (PAIR_W'(1) << (DATA_W - 1)) : ((PAIR_W'(1) << (DATA_W - 1)) - 1'b1);
    assign m   = (lo > lim) ? lim : lo;
    assign sat[i] = neg_r[i] ? DATA_W'(-m) : m[DATA_W-1:0];
  end

  logic [DATA_W-1:0] big_q;
  assign big_q = DATA_W'(bigm_r);

  logic [DATA_W-1:0] qw_nxt, qx_nxt, qy_nxt, qz_nxt;
  always_comb begin
    case (idxm_r)
      IDX_W: begin
        qw_nxt = big_q;  qx_nxt = sat[0]; qy_nxt = sat[1]; qz_nxt = sat[2];
      end
      IDX_X: begin
        qw_nxt = sat[0]; qx_nxt = big_q;  qy_nxt = sat[1]; qz_nxt = sat[2];
      end
      IDX_Y: begin
        qw_nxt = sat[0]; qx_nxt = sat[1]; qy_nxt = big_q;  qz_nxt = sat[2];
      end
      IDX_Z: begin
        qw_nxt = sat[0]; qx_nxt = sat[1]; qy_nxt = sat[2]; qz_nxt = big_q;
      end
      default: begin
        qw_nxt = big_q;  qx_nxt = sat[0]; qy_nxt = sat[1]; qz_nxt = sat[2];
      end
    endcase
  end

  logic [DATA_W-1:0] qw_r, qx_r, qy_r, qz_r;
  idx_t              idxo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qw_r   <= qw_nxt;
      qx_r   <= qx_nxt;
      qy_r   <= qy_nxt;
      qz_r   <= qz_nxt;
      idxo_r <= idxm_r;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.qw            = qw_r;
  assign out_ch.qx            = qx_r;
  assign out_ch.qy            = qy_r;
  assign out_ch.qz            = qz_r;
  assign out_ch.largest_index = idxo_r;
endmodule
`default_nettype wire

[src/rmq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module rmq_checker
  import rmq_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [31:0] qw,
  input wire logic signed [31:0] qx,
  input wire logic signed [31:0] qy,
  input wire logic signed [31:0] qz,
  input wire logic [1:0]         largest_index
);
  localparam logic signed [31:0] HALF_MIN = 32'sd1 <<< (FRAC_BITS - 1);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(qw) && $stable(largest_index))
    else $error("stalled beat changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("beat right after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_big: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (largest_index == IDX_W && qw >= HALF_MIN)
               || (largest_index == IDX_X && qx >= HALF_MIN)
               || (largest_index == IDX_Y && qy >= HALF_MIN)
               || (largest_index == IDX_Z && qz >= HALF_MIN))
    else $error("chosen component below one half");
endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .qw            (out_ch.qw),
  .qx            (out_ch.qx),
  .qy            (out_ch.qy),
  .qz            (out_ch.qz),
  .largest_index (out_ch.largest_index)
);
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
  import rmq_pkg::*;

  typedef logic signed [31:0] mat_t [9];

  typedef struct {
    logic signed [31:0] qw, qx, qy, qz;
    idx_t               idx;
  } quat_t;

  class quat_board;
    quat_t quat_q[$];
    int    mismatches;

    static function automatic logic [31:0] scale_pair(longint pr, logic [127:0] mult);
      bit          neg;
      logic [63:0] mag;
      logic [127:0] q;
      logic [127:0] limit;
      neg   = pr < 0;
      mag   = neg ? -pr : pr;
      q     = ({64'd0, mag} * mult) >> FRAC_BITS;
      limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > limit) q = limit;
      return neg ? -q[31:0] : q[31:0];
    endfunction

    function void note_matrix(mat_t m);
      longint       t [4];
      longint       p [4];
      longint       one;
      int           k;
      logic [127:0] n, cand, mult;
      logic [63:0]  rt, big;
      quat_t        r;
      logic [31:0]  o [4];
      one  = longint'(1) << FRAC_BITS;
      t[0] = longint'(m[0]) + m[4] + m[8];
      t[1] = longint'(m[0]) - m[4] - m[8];
      t[2] = longint'(m[4]) - m[0] - m[8];
      t[3] = longint'(m[8]) - m[0] - m[4];
      k = 0;
      for (int j = 1; j < 4; j++) if (t[j] > t[k]) k = j;
      n  = 128'(t[k] + one) << FRAC_BITS;
      rt = 0;
      for (int b = 63; b >= 0; b--) begin
        cand = {64'd0, rt | (64'd1 << b)};
        if (cand * cand <= n) rt = cand[63:0];
      end
      big  = rt >> 1;
      mult = (128'd1 << (2 * FRAC_BITS - 2)) / {64'd0, big};
      p = '{0, 0, 0, 0};
      case (k)
        IDX_W: begin
          p[1] = longint'(m[7]) - m[5]; p[2] = longint'(m[2]) - m[6];
          p[3] = longint'(m[3]) - m[1];
        end
        IDX_X: begin
          p[0] = longint'(m[7]) - m[5]; p[2] = longint'(m[3]) + m[1];
          p[3] = longint'(m[2]) + m[6];
        end
        IDX_Y: begin
          p[0] = longint'(m[2]) - m[6]; p[1] = longint'(m[3]) + m[1];
          p[3] = longint'(m[7]) + m[5];
        end
        default: begin
          p[0] = longint'(m[3]) - m[1]; p[1] = longint'(m[2]) + m[6];
          p[2] = longint'(m[7]) + m[5];
        end
      endcase
      for (int j = 0; j < 4; j++)
        o[j] = (j == k) ? ((big > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : big[31:0])
                        : scale_pair(p[j], mult);
      r.qw = o[0]; r.qx = o[1]; r.qy = o[2]; r.qz = o[3];
      r.idx = idx_t'(k);
      quat_q.push_back(r);
    endfunction

    function void check_quat(quat_t got);
      quat_t e;
      if (quat_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat qw=%0d qx=%0d qy=%0d qz=%0d idx=%0d",
                   got.qw, got.qx, got.qy, got.qz, got.idx);
        return;
      end
      e = quat_q.pop_front();
      if (got.qw !== e.qw || got.qx !== e.qx || got.qy !== e.qy || got.qz !== e.qz ||
          got.idx !== e.idx) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp %0d %0d %0d %0d idx %0d, got %0d %0d %0d %0d idx %0d",
                   e.qw, e.qx, e.qy, e.qz, e.idx, got.qw, got.qx, got.qy, got.qz, got.idx);
      end
    endfunction
  endclass

  localparam int ONE_Q = 1 << 30;

  logic clk = 0;
  logic rst_n;
  always #6 clk = ~clk;

  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();

  rotation_matrix_to_quaternion DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  quat_board sb = new();
  bit        no_gaps;
  bit        hold_req;

  initial begin
    in_ch.valid <= 0;
    {in_ch.e11, in_ch.e12, in_ch.e13, in_ch.e21, in_ch.e22} <= '0;
    {in_ch.e23, in_ch.e31, in_ch.e32, in_ch.e33} <= '0;
    out_ch.ready <= 0;
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold == 0) begin
        hold     = 400;
        hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 0;
      end else if (no_gaps) out_ch.ready <= 1;
      else out_ch.ready <= ($urandom_range(0, 9) < 7);
    end
  end

  always @(posedge clk) begin
    quat_t g;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      g.qw = out_ch.qw; g.qx = out_ch.qx; g.qy = out_ch.qy; g.qz = out_ch.qz;
      g.idx = idx_t'(out_ch.largest_index);
      sb.check_quat(g);
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_matrix(mat_t m);
    int g;
    in_ch.valid <= 1;
    in_ch.e11 <= m[0]; in_ch.e12 <= m[1]; in_ch.e13 <= m[2];
    in_ch.e21 <= m[3]; in_ch.e22 <= m[4]; in_ch.e23 <= m[5];
    in_ch.e31 <= m[6]; in_ch.e32 <= m[7]; in_ch.e33 <= m[8];
    do @(posedge clk); while (!in_ch.ready);
    sb.note_matrix(m);
    g = idle_len();
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] to_fix(real v);
    real s;
    s = v * ONE_Q;
    if (s > ONE_Q) s = ONE_Q;
    if (s < -ONE_Q) s = -ONE_Q;
    return $rtoi(s);
  endfunction

  function automatic real rnd_unit();
    return ($itor($urandom_range(0, 2000000)) - 1000000.0) / 1000000.0;
  endfunction

  function automatic void rotation(output mat_t m);
    real w, x, y, z, s;
    do begin
      w = rnd_unit(); x = rnd_unit(); y = rnd_unit(); z = rnd_unit();
      s = w * w + x * x + y * y + z * z;
    end while (s < 0.01);
    s = $sqrt(s);
    w = w / s; x = x / s; y = y / s; z = z / s;
    m[0] = to_fix(1 - 2 * (y * y + z * z));
    m[1] = to_fix(2 * (x * y - w * z));
    m[2] = to_fix(2 * (x * z + w * y));
    m[3] = to_fix(2 * (x * y + w * z));
    m[4] = to_fix(1 - 2 * (x * x + z * z));
    m[5] = to_fix(2 * (y * z - w * x));
    m[6] = to_fix(2 * (x * z - w * y));
    m[7] = to_fix(2 * (y * z + w * x));
    m[8] = to_fix(1 - 2 * (x * x + y * y));
  endfunction

  function automatic logic signed [31:0] rnd_elem();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return ONE_Q;
    if (r == 1) return -ONE_Q;
    if (r == 2) return 0;
    return $signed($urandom_range(0, 2 * ONE_Q)) - ONE_Q;
  endfunction

  task automatic random_item();
    mat_t m;
    if ($urandom_range(0, 9) < 7) rotation(m);
    else foreach (m[i]) m[i] = rnd_elem();
    send_matrix(m);
  endtask

  task automatic directed();
    mat_t m;
    int   d [9];
    for (int c = 0; c < 22; c++) begin
      foreach (d[i]) d[i] = 0;
      case (c)
        0: begin d[0] = ONE_Q; d[4] = ONE_Q; d[8] = ONE_Q; end
        1: begin d[0] = ONE_Q; d[4] = -ONE_Q; d[8] = -ONE_Q; end
        2: begin d[0] = -ONE_Q; d[4] = ONE_Q; d[8] = -ONE_Q; end
        3: begin d[0] = -ONE_Q; d[4] = -ONE_Q; d[8] = ONE_Q; end
        4: ;
        5: foreach (d[i]) d[i] = ONE_Q;
        6: foreach (d[i]) d[i] = -ONE_Q;
        7: begin d[0] = -ONE_Q; d[4] = -ONE_Q; d[8] = -ONE_Q; end
        8: begin foreach (d[i]) d[i] = -ONE_Q; d[0] = ONE_Q; end
        9: begin foreach (d[i]) d[i] = ONE_Q; d[0] = -ONE_Q; d[4] = -ONE_Q; end
        10: begin d[1] = ONE_Q; d[3] = -ONE_Q; d[8] = ONE_Q; end
        11: begin d[0] = ONE_Q; d[4] = ONE_Q; d[8] = -ONE_Q; d[1] = -ONE_Q; end
        12: begin d[0] = -1; d[4] = -1; d[8] = 1; d[2] = ONE_Q; d[6] = ONE_Q; end
        13: begin d[2] = -ONE_Q; d[6] = ONE_Q; d[5] = ONE_Q; d[7] = -ONE_Q; d[4] = -ONE_Q; end
        14: begin d[0] = 1; d[1] = -1; d[2] = 1; d[3] = -1; d[5] = 1; end
        15: begin d[0] = ONE_Q / 3; d[4] = ONE_Q / 3; d[8] = ONE_Q / 3; end
        default: ;
      endcase
      if (c >= 16) rotation(m);
      else foreach (m[i]) m[i] = d[i];
      send_matrix(m);
    end
  endtask

  initial begin
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    directed();
    hold_req = 1;
    for (int i = 0; i < 120; i++) random_item();
    in_ch.valid <= 0;
    while (sb.quat_q.size() != 0) @(posedge clk);
    for (int i = 0; i < 1400; i++) begin
      if (i % 300 == 0) no_gaps = ($urandom_range(0, 1) == 0);
      random_item();
    end
    in_ch.valid <= 0;
    while (sb.quat_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (sb.mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #8000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
